// File: rtl/look_at_view_matrix_assert.svh
// ----------------------------------------------------------------------------
// look_at_view_matrix assertion macros
// shared concurrent assertion forms, clocked on clk, quiet during rst
// ----------------------------------------------------------------------------
`ifndef LOOK_AT_VIEW_MATRIX_ASSERT_SVH
`define LOOK_AT_VIEW_MATRIX_ASSERT_SVH

// expression holds on every clock edge out of reset
`define LAVM_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// cause holds in one cycle, effect holds in the next
`define LAVM_ASSERT_NEXT(lbl, cause, effect, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) \
    else $error(msg);

`endif

// File: rtl/lavm_pkg.sv
// ----------------------------------------------------------------------------
// lavm_pkg
// shared types and constants of the look-at view matrix builder
// ----------------------------------------------------------------------------
package lavm_pkg;

  localparam int FRAC_BITS_DEF   = 16;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int UNIT_FRAC       = 30;  // unit vectors are q2.30
  localparam int NUM_COLS        = 4;

  typedef logic signed [31:0] coord_t;
  typedef logic signed [32:0] diff_t;
  typedef logic signed [63:0] wide_t;

  // one accepted item after the front stage
  typedef struct packed {
    coord_t [2:0] eye;
    diff_t  [2:0] d;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic ok;
  } norm_stat_t;

  localparam logic [1:0] COL_LAST = 2'(NUM_COLS - 1);

endpackage

// File: rtl/lavm_front.sv
// ----------------------------------------------------------------------------
// lavm_front
// accepts an item, forms the eye to target difference, pushes it to the queue
// ----------------------------------------------------------------------------
module lavm_front
  import lavm_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [191:0] s_tdata,   // eye_x, eye_y, eye_z, target_x, target_y, target_z
  output logic         push,
  output item_t        item,
  input  qstat_t       qstat
);

  logic            hold;
  coord_t          eye [3];
  coord_t          tgt [3];

  assign push     = hold && !qstat.full;
  assign s_tready = !hold || !qstat.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      hold <= 1'b1;
    end else if (push) begin
      hold <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      for (int i = 0; i < 3; i++) begin
        eye[i] <= s_tdata[32*i +: 32];
        tgt[i] <= s_tdata[96 + 32*i +: 32];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      item.eye[i] = eye[i];
      item.d[i]   = $signed({tgt[i][31], tgt[i]}) - $signed({eye[i][31], eye[i]});
    end
  end

endmodule

// File: rtl/lavm_queue.sv
// ----------------------------------------------------------------------------
// lavm_queue
// short item queue between the front and the back
// ----------------------------------------------------------------------------
module lavm_queue
  import lavm_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  item_t  item_in,
  input  logic   pop,
  output item_t  item_out,
  output qstat_t qstat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t         slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign qstat.full  = (count == CW'(DEPTH));
  assign qstat.empty = (count == '0);
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign item_out    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= item_in;
    end
  end

endmodule

// File: rtl/lavm_norm.sv
// ----------------------------------------------------------------------------
// lavm_norm
// iterative vector normalizer: scale, sum of squares, bit serial root, divides
// ----------------------------------------------------------------------------
module lavm_norm
  import lavm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  wide_t      vin [3],
  output norm_stat_t stat,
  output coord_t     vout [3]
);

  typedef enum logic [6:0] {
    N_IDLE  = 7'b0000001,
    N_SHIFT = 7'b0000010,
    N_SQ    = 7'b0000100,
    N_ACC   = 7'b0001000,
    N_SQRT  = 7'b0010000,
    N_DSET  = 7'b0100000,
    N_DIV   = 7'b1000000
  } nstate_t;

  nstate_t       state;
  logic [62:0]   mag [3];
  logic          neg [3];
  logic [63:0]   sum;
  logic [61:0]   prod;
  logic [35:0]   rem;
  logic [31:0]   root;
  logic [31:0]   drem;
  logic [30:0]   nlo;
  logic [4:0]    iter;
  logic [1:0]    idx;
  logic          done;
  logic          ok;

  logic [35:0]   rem_try;
  logic [35:0]   trial;
  logic [61:0]   num;
  logic [32:0]   dtry;
  logic          big;
  logic          all_zero;

  assign stat.busy = (state != N_IDLE);
  assign stat.done = done;
  assign stat.ok   = ok;

  always_comb begin
    big      = 1'b0;
    all_zero = 1'b1;
    for (int i = 0; i < 3; i++) begin
      big      = big | (|mag[i][62:31]);
      all_zero = all_zero & (vin[i] == '0);
    end
    rem_try = {rem[33:0], sum[63:62]};
    trial   = {2'b00, root, 2'b01};
    // dividend is the magnitude in q2.30 plus half the length
    num     = {1'b0, mag[idx][30:0], 30'(0)} + 62'(root >> 1);
    dtry    = {drem, nlo[30]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
      done  <= 1'b0;
      ok    <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        N_IDLE: begin
          if (start) begin
            for (int i = 0; i < 3; i++) begin
              mag[i] <= vin[i][63] ? 63'(-vin[i]) : vin[i][62:0];
              neg[i] <= vin[i][63];
            end
            if (all_zero) begin
              for (int i = 0; i < 3; i++) vout[i] <= '0;
              ok   <= 1'b0;
              done <= 1'b1;
            end else begin
              state <= N_SHIFT;
            end
          end
        end
        N_SHIFT: begin
          // one bit a cycle until the largest magnitude is under 2^31
          if (big) begin
            for (int i = 0; i < 3; i++) mag[i] <= mag[i] >> 1;
          end else begin
            state <= N_SQ;
            idx   <= '0;
            prod  <= '0;
            sum   <= '0;
          end
        end
        N_SQ: begin
          prod <= mag[idx][30:0] * mag[idx][30:0];
          sum  <= sum + 64'(prod);
          if (idx == 2'd2) begin
            state <= N_ACC;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        N_ACC: begin
          sum   <= sum + 64'(prod);
          rem   <= '0;
          root  <= '0;
          iter  <= '0;
          state <= N_SQRT;
        end
        N_SQRT: begin
          if (rem_try >= trial) begin
            rem  <= rem_try - trial;
            root <= {root[30:0], 1'b1};
          end else begin
            rem  <= rem_try;
            root <= {root[30:0], 1'b0};
          end
          sum  <= sum << 2;
          iter <= iter + 1'b1;
          if (iter == 5'd31) begin
            idx   <= '0;
            state <= N_DSET;
          end
        end
        N_DSET: begin
          drem  <= {1'b0, num[61:31]};
          nlo   <= num[30:0];
          iter  <= '0;
          state <= N_DIV;
        end
        N_DIV: begin
          if (dtry >= {1'b0, root}) begin
            drem <= 32'(dtry - {1'b0, root});
            nlo  <= {nlo[29:0], 1'b1};
          end else begin
            drem <= dtry[31:0];
            nlo  <= {nlo[29:0], 1'b0};
          end
          iter <= iter + 1'b1;
          if (iter == 5'd30) begin
            vout[idx] <= neg[idx] ? -$signed({1'b0, nlo[29:0], dtry >= {1'b0, root}})
                                  :  $signed({1'b0, nlo[29:0], dtry >= {1'b0, root}});
            if (idx == 2'd2) begin
              ok    <= 1'b1;
              done  <= 1'b1;
              state <= N_IDLE;
            end else begin
              idx   <= idx + 1'b1;
              state <= N_DSET;
            end
          end
        end
        default: state <= N_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/lavm_back.sv
// ----------------------------------------------------------------------------
// lavm_back
// per item sequencer: three normalizations, cross and dot products, columns out
// ----------------------------------------------------------------------------
module lavm_back
  import lavm_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         q_valid,
  input  item_t        q_item,
  output logic         q_pop,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,   // elem0, elem1, elem2, elem3
  output logic [2:0]   m_tuser,   // column_index, degenerate
  output logic         m_tlast
);

  `include "look_at_view_matrix_assert.svh"

  localparam int SH = UNIT_FRAC - FRAC_BITS;
  localparam logic [3:0] CROSS_STEPS = 4'd6;
  localparam logic [3:0] DOT_STEPS   = 4'd9;

  typedef enum logic [6:0] {
    B_POP   = 7'b0000001,
    B_NF    = 7'b0000010,
    B_NR    = 7'b0000100,
    B_CROSS = 7'b0001000,
    B_NU    = 7'b0010000,
    B_DOT   = 7'b0100000,
    B_EMIT  = 7'b1000000
  } bstate_t;

  bstate_t    state;
  coord_t     eye [3];
  coord_t     fv [3];
  coord_t     rv [3];
  coord_t     uv [3];
  wide_t      acc [3];
  logic       ok;
  logic [3:0] step;
  wide_t      prod;
  logic [1:0] pdst;
  logic       pneg;
  logic       pv;
  logic [1:0] col;
  logic [1:0] out_col;
  logic       out_deg;

  logic       n_start;
  wide_t      n_vin [3];
  norm_stat_t n_stat;
  coord_t     n_vout [3];

  coord_t     op_a;
  coord_t     op_b;
  logic [1:0] op_dst;
  logic       op_neg;
  logic [3:0] nsteps;
  logic       load;
  logic [31:0] el [4];

  lavm_norm u_norm (
    .clk  (clk),
    .rst  (rst),
    .start(n_start),
    .vin  (n_vin),
    .stat (n_stat),
    .vout (n_vout)
  );

  function automatic coord_t unit_conv(input coord_t v);
    logic [31:0] m;
    logic [31:0] r;
    m = v[31] ? 32'(-v) : 32'(v);
    r = (m + (32'(1) << (SH - 1))) >> SH;
    return v[31] ? -$signed(r) : $signed(r);
  endfunction

  function automatic coord_t dot_conv(input wide_t a, input logic negate);
    wide_t       d;
    logic [63:0] m;
    logic [33:0] r;
    d = negate ? -a : a;
    m = d[63] ? 64'(-d) : 64'(d);
    r = 34'((m + (64'(1) << (UNIT_FRAC - 1))) >> UNIT_FRAC);
    if (!d[63] && r > 34'h07fffffff) return 32'h7fffffff;
    if (d[63] && r > 34'h080000000) return 32'h80000000;
    return d[63] ? -$signed(r[31:0]) : $signed(r[31:0]);
  endfunction

  // operand schedule of the shared multiplier
  always_comb begin
    op_a   = rv[0];
    op_b   = eye[0];
    op_dst = 2'd0;
    op_neg = 1'b0;
    if (state == B_CROSS) begin
      case (step)
        4'd0: begin op_a = rv[1]; op_b = fv[2]; op_dst = 2'd0; end
        4'd1: begin op_a = rv[2]; op_b = fv[1]; op_dst = 2'd0; op_neg = 1'b1; end
        4'd2: begin op_a = rv[2]; op_b = fv[0]; op_dst = 2'd1; end
        4'd3: begin op_a = rv[0]; op_b = fv[2]; op_dst = 2'd1; op_neg = 1'b1; end
        4'd4: begin op_a = rv[0]; op_b = fv[1]; op_dst = 2'd2; end
        4'd5: begin op_a = rv[1]; op_b = fv[0]; op_dst = 2'd2; op_neg = 1'b1; end
        default: ;
      endcase
    end else begin
      case (step)
        4'd0: begin op_a = rv[0]; op_b = eye[0]; op_dst = 2'd0; end
        4'd1: begin op_a = rv[1]; op_b = eye[1]; op_dst = 2'd0; end
        4'd2: begin op_a = rv[2]; op_b = eye[2]; op_dst = 2'd0; end
        4'd3: begin op_a = uv[0]; op_b = eye[0]; op_dst = 2'd1; end
        4'd4: begin op_a = uv[1]; op_b = eye[1]; op_dst = 2'd1; end
        4'd5: begin op_a = uv[2]; op_b = eye[2]; op_dst = 2'd1; end
        4'd6: begin op_a = fv[0]; op_b = eye[0]; op_dst = 2'd2; end
        4'd7: begin op_a = fv[1]; op_b = eye[1]; op_dst = 2'd2; end
        4'd8: begin op_a = fv[2]; op_b = eye[2]; op_dst = 2'd2; end
        default: ;
      endcase
    end
    nsteps = (state == B_CROSS) ? CROSS_STEPS : DOT_STEPS;
  end

  // normalizer launch
  always_comb begin
    n_start = 1'b0;
    for (int i = 0; i < 3; i++) n_vin[i] = 64'(signed'(q_item.d[i]));
    case (state)
      B_POP:   n_start = q_valid;
      B_NF: begin
        n_start  = n_stat.done;
        n_vin[0] = 64'(signed'(n_vout[1]));
        n_vin[1] = -64'(signed'(n_vout[0]));
        n_vin[2] = '0;
      end
      B_CROSS: begin
        n_start = (step == nsteps + 1'b1);
        for (int i = 0; i < 3; i++) n_vin[i] = acc[i];
      end
      default: ;
    endcase
  end

  assign q_pop = (state == B_POP) && q_valid;
  assign load  = (state == B_EMIT) && (!m_tvalid || m_tready);

  // column elements
  always_comb begin
    el[0] = '0;
    el[1] = '0;
    el[2] = '0;
    el[3] = '0;
    case (col)
      2'd0, 2'd1, 2'd2: begin
        el[0] = unit_conv(rv[col]);
        el[1] = unit_conv(uv[col]);
        el[2] = unit_conv(-fv[col]);
      end
      COL_LAST: begin
        el[0] = dot_conv(acc[0], 1'b1);
        el[1] = dot_conv(acc[1], 1'b1);
        el[2] = dot_conv(acc[2], 1'b0);
        el[3] = 32'(1) << FRAC_BITS;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_POP;
      m_tvalid <= 1'b0;
      pv       <= 1'b0;
      ok       <= 1'b1;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        B_POP: begin
          if (q_valid) begin
            ok    <= 1'b1;
            state <= B_NF;
          end
        end
        B_NF: begin
          if (n_stat.done) begin
            ok    <= ok & n_stat.ok;
            state <= B_NR;
          end
        end
        B_NR: begin
          if (n_stat.done) begin
            ok    <= ok & n_stat.ok;
            step  <= '0;
            pv    <= 1'b0;
            state <= B_CROSS;
          end
        end
        B_CROSS, B_DOT: begin
          pv   <= (step < nsteps);
          step <= step + 1'b1;
          if (step == nsteps + 1'b1) begin
            state <= (state == B_CROSS) ? B_NU : B_EMIT;
            col   <= '0;
          end
        end
        B_NU: begin
          if (n_stat.done) begin
            ok    <= ok & n_stat.ok;
            step  <= '0;
            pv    <= 1'b0;
            state <= B_DOT;
          end
        end
        B_EMIT: begin
          if (load) begin
            col <= col + 1'b1;
            if (col == COL_LAST) state <= B_POP;
          end
        end
        default: state <= B_POP;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == B_POP && q_valid) begin
      for (int i = 0; i < 3; i++) eye[i] <= q_item.eye[i];
    end
    if (state == B_NF && n_stat.done) begin
      for (int i = 0; i < 3; i++) fv[i] <= n_vout[i];
    end
    if (state == B_NR && n_stat.done) begin
      for (int i = 0; i < 3; i++) begin
        rv[i]  <= n_vout[i];
        acc[i] <= '0;
      end
    end
    if (state == B_NU && n_stat.done) begin
      for (int i = 0; i < 3; i++) begin
        uv[i]  <= n_vout[i];
        acc[i] <= '0;
      end
    end
    if (state == B_CROSS || state == B_DOT) begin
      prod <= op_a * op_b;
      pdst <= op_dst;
      pneg <= op_neg;
      if (pv) begin
        acc[pdst] <= pneg ? acc[pdst] - prod : acc[pdst] + prod;
      end
    end
    if (load) begin
      m_tdata <= {el[3], el[2], el[1], el[0]};
      out_col <= col;
      out_deg <= !ok;
      m_tlast <= (col == COL_LAST);
    end
  end

  assign m_tuser = {out_deg, out_col};

  `LAVM_ASSERT(a_start_idle, !n_start || !n_stat.busy, "normalizer started while busy")
  `LAVM_ASSERT(a_cols_in_emit, !(m_tvalid && out_col != COL_LAST) || state == B_EMIT,
    "early column shown outside emit")
  `LAVM_ASSERT_NEXT(a_col_seq, m_tvalid && m_tready && !m_tlast,
    m_tvalid && out_col == $past(out_col) + 2'd1 && $stable(out_deg),
    "column sequence broken")

endmodule

// File: rtl/look_at_view_matrix.sv
// ----------------------------------------------------------------------------
// look_at_view_matrix
// builds a column-major look-at view matrix from an eye and a target point
// ----------------------------------------------------------------------------
//  channel   dir  bits  payload
//  s_*       in   192   eye_x, eye_y, eye_z, target_x, target_y, target_z
//  m_*       out  128   elem0..elem3; tuser column_index, degenerate; tlast
//
// per item the back sequencer runs three normalizations, 15 multiplies and
// 4 columns; per vector the normalizer shifts the magnitudes down, takes a 32 bit
// bit serial root and three divides, and skips all of these on a zero-length vector
// the front and queue keep taking items while the back is busy, until both are full
// rst is synchronous and clears all control state, no clearing pass
// each side stalls on its own: the queue and the output register part them
module look_at_view_matrix
  import lavm_pkg::*;
#(
  parameter int FRAC_BITS   = FRAC_BITS_DEF,    // fraction bits of in and out
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF   // items held between front and back
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [191:0] s_tdata,   // eye_x, eye_y, eye_z, target_x, target_y, target_z
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,   // elem0, elem1, elem2, elem3
  output logic [2:0]   m_tuser,   // column_index, degenerate
  output logic         m_tlast
);

  logic   push;
  item_t  push_item;
  qstat_t qstat;
  logic   pop;
  item_t  head_item;

  // front: take item, form target minus eye
  lavm_front u_front (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .push    (push),
    .item    (push_item),
    .qstat   (qstat)
  );

  // decoupling queue
  lavm_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .item_in (push_item),
    .pop     (pop),
    .item_out(head_item),
    .qstat   (qstat)
  );

  // back: normalize, cross, dot, four column items
  lavm_back #(
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (!qstat.empty),
    .q_item  (head_item),
    .q_pop   (pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

endmodule

// File: sim/tb_look_at_view_matrix.sv
// ----------------------------------------------------------------------------
// tb_look_at_view_matrix
// checks the four view matrix columns of every eye and target item against
// a bit-exact fixed-point predictor, with random stalls on both streams
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_look_at_view_matrix;
  import lavm_pkg::*;

  localparam int  FRAC      = FRAC_BITS_DEF;
  localparam int  LIMIT     = 2000000;
  localparam int  DRAIN     = 1500;

  typedef longint vec3_t [3];

  typedef struct {
    logic [1:0]  col;
    logic [31:0] elem [4];
    logic        degen;
    logic        last;
  } column_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [191:0] s_tdata;    // eye_x, eye_y, eye_z, target_x, target_y, target_z
  logic         m_tvalid;
  logic         m_tready;
  logic [127:0] m_tdata;    // elem0, elem1, elem2, elem3
  logic [2:0]   m_tuser;    // column_index, degenerate
  logic         m_tlast;

  column_t columns_due [$];
  int          errors;
  int          cycles;
  int          hold_cycles;   // one-shot long stall asked of the receiver
  bit          no_idle;       // stretches with no gaps on either side

  look_at_view_matrix dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  // ---------------------------------------------------------------------------
  // fixed-point predictor
  // ---------------------------------------------------------------------------
  function automatic longint unsigned magnitude(longint v);
    return v < 0 ? 64'd0 - longint'(unsigned'(v)) : longint'(unsigned'(v));
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // q2.30 unit vector, zero vector and 0 on zero length
  function automatic bit normalize(input vec3_t v, output vec3_t u);
    longint unsigned m [3];
    longint unsigned mx, sum, len, q;
    int s;
    mx = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = magnitude(v[i]);
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) begin
      u[0] = 0; u[1] = 0; u[2] = 0;
      return 1'b0;
    end
    s = 0;
    while ((mx >> s) >= (64'd1 << 31)) s++;
    for (int i = 0; i < 3; i++) begin
      m[i] = m[i] >> s;
      sum = sum + m[i] * m[i];
    end
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << 30) + (len >> 1)) / len;
      u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
    return 1'b1;
  endfunction

  // shift right, rounding half away from zero
  function automatic longint round_shift(longint v, int sh);
    longint unsigned m;
    m = magnitude(v);
    m = (m + (64'd1 << (sh - 1))) >> sh;
    return v < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic [31:0] translation(vec3_t a, vec3_t p, bit neg);
    longint d;
    d = a[0] * p[0] + a[1] * p[1] + a[2] * p[2];
    if (neg) d = -d;
    d = round_shift(d, UNIT_FRAC);
    if (d > 64'sd2147483647) d = 64'sd2147483647;
    if (d < -64'sd2147483648) d = -64'sd2147483648;
    return d[31:0];
  endfunction

  function automatic logic [31:0] unit_elem(longint v);
    longint t;
    t = round_shift(v, UNIT_FRAC - FRAC);
    return t[31:0];
  endfunction

  // push the four expected columns of one eye/target pair
  task automatic predict_view(logic [191:0] pkt);
    vec3_t eye, d, f, rc, r, uc, u;
    bit ok;
    column_t c;
    for (int i = 0; i < 3; i++) begin
      eye[i] = longint'($signed(pkt[32*i +: 32]));
      d[i]   = longint'($signed(pkt[32*(i+3) +: 32])) - eye[i];
    end
    ok = normalize(d, f);
    // f x up with up = +z
    rc[0] = f[1]; rc[1] = -f[0]; rc[2] = 0;
    ok &= normalize(rc, r);
    uc[0] = r[1] * f[2] - r[2] * f[1];
    uc[1] = r[2] * f[0] - r[0] * f[2];
    uc[2] = r[0] * f[1] - r[1] * f[0];
    ok &= normalize(uc, u);
    for (int k = 0; k < NUM_COLS; k++) begin
      c.col   = 2'(k);
      c.degen = !ok;
      c.last  = (k == NUM_COLS - 1);
      if (k < 3) begin
        c.elem[0] = unit_elem(r[k]);
        c.elem[1] = unit_elem(u[k]);
        c.elem[2] = unit_elem(-f[k]);
        c.elem[3] = 32'd0;
      end else begin
        c.elem[0] = translation(r, eye, 1'b1);
        c.elem[1] = translation(u, eye, 1'b1);
        c.elem[2] = translation(f, eye, 1'b0);
        c.elem[3] = 32'd1 << FRAC;
      end
      columns_due.push_back(c);
    end
  endtask

  // ---------------------------------------------------------------------------
  // sender
  // ---------------------------------------------------------------------------
  task automatic send_item(logic [31:0] ex, logic [31:0] ey, logic [31:0] ez,
                           logic [31:0] tx, logic [31:0] ty, logic [31:0] tz);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {tz, ty, tx, ez, ey, ex};
    // ready is looked at mid-cycle, the item goes at the next rising edge
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
    predict_view({tz, ty, tx, ez, ey, ex});
  endtask

  task automatic go_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (columns_due.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // receiver and checker
  // ---------------------------------------------------------------------------
  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at cycle %0d: %s got %h want %h", cycles, what, got, want);
    errors++;
  endtask

  initial begin
    column_t want;
    int gap;
    bit hold_done;
    hold_done = 1'b0;
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_cycles > 0 && !hold_done) begin
        m_tready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_done = 1'b1;
      end
      gap = no_idle ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(negedge clk); while (!m_tvalid);
      if (columns_due.size() == 0) begin
        report("column with none due", m_tdata[31:0], 32'd0);
      end else begin
        want = columns_due.pop_front();
        if (m_tuser[1:0] != want.col)
          report("column_index", 32'(m_tuser[1:0]), 32'(want.col));
        for (int i = 0; i < 4; i++)
          if (m_tdata[32*i +: 32] !== want.elem[i])
            report($sformatf("col %0d elem%0d", want.col, i),
                   m_tdata[32*i +: 32], want.elem[i]);
        if (m_tuser[2] !== want.degen)
          report("degenerate", 32'(m_tuser[2]), 32'(want.degen));
        if (m_tlast !== want.last) report("tlast", 32'(m_tlast), 32'(want.last));
      end
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout with %0d columns due", columns_due.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  task automatic test_special_cases();
    // eye equals target, at zero and at the extremes
    send_item(0, 0, 0, 0, 0, 0);
    send_item(32'h8000_0000, 32'h7fff_ffff, 32'h1234_5678,
              32'h8000_0000, 32'h7fff_ffff, 32'h1234_5678);
    // looking straight along z, up and down
    send_item(32'h0001_0000, 32'hfffe_0000, 0, 32'h0001_0000, 32'hfffe_0000, 32'h0005_0000);
    send_item(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
              32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
    // widest spans in every direction
    send_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_item(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_item(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
              32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    // translation saturates with the eye far out
    send_item(32'h7fff_0000, 32'h7fff_0000, 32'h7fff_0000,
              32'h7ffe_0000, 32'h7ffe_0000, 32'h7ffe_0000);
    send_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h8001_0000, 32'h8001_0000, 32'h8001_0000);
    // tiny steps of one lsb, and a step one lsb off the z axis
    send_item(0, 0, 0, 1, 0, 0);
    send_item(0, 0, 0, 0, 32'hffff_ffff, 0);
    send_item(0, 0, 0, 1, 1, 32'h7fff_ffff);
    // usual camera, diagonal and off axis in the yz plane
    send_item(32'h0005_0000, 32'h0005_0000, 32'h0005_0000, 0, 0, 0);
    send_item(0, 32'hfff6_0000, 32'h0002_0000, 0, 0, 0);
    go_idle();
    wait_drained();
  endtask

  task automatic send_random_view(int kind);
    logic [31:0] e [3];
    logic [31:0] t [3];
    for (int i = 0; i < 3; i++) e[i] = $urandom();
    case (kind)
      0: for (int i = 0; i < 3; i++) t[i] = $urandom();
      1: for (int i = 0; i < 3; i++) t[i] = e[i] + 32'($signed($urandom_range(0, 2000)) - 1000);
      2: begin
        t[0] = e[0]; t[1] = e[1]; t[2] = $urandom();
      end
      default: for (int i = 0; i < 3; i++) t[i] = e[i];
    endcase
    send_item(e[0], e[1], e[2], t[0], t[1], t[2]);
  endtask

  task automatic test_random_views(int n);
    int k;
    for (int j = 0; j < n; j++) begin
      if (j % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
      k = $urandom_range(0, 19);
      send_random_view(k < 12 ? 0 : k < 17 ? 1 : k < 19 ? 2 : 3);
    end
    no_idle = 1'b0;
    go_idle();
    wait_drained();
  endtask

  // receiver holds off while items keep coming, so the queue fills up
  task automatic test_backpressure();
    hold_cycles = 4000;
    for (int j = 0; j < 12; j++) send_random_view(j % 2);
    go_idle();
    wait_drained();
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    hold_cycles = 0;
    no_idle = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_special_cases();
    test_random_views(110);
    test_backpressure();
    test_random_views(95);

    repeat (DRAIN) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
